// ===== rtl/ssx_pkg.sv =====
// ssx_pkg: widths, types and selection codes for the source selector crossfade.
// No dependencies; imported by every module of the block.
package ssx_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int FADE_BITS   = 20;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_SHIFT  = 14;
    localparam int IDX_BITS    = 4;
    localparam int SEL_BITS    = 5;

    localparam logic [SEL_BITS-1:0] SEL_NONE = SEL_BITS'(0);
    localparam logic [SEL_BITS-1:0] SEL_ALL  = SEL_BITS'(17);

    // shared multiplier: signed sample or zero-extended fade value times unsigned weight
    localparam int MUL_A_W = (SAMPLE_BITS > FADE_BITS) ? SAMPLE_BITS : FADE_BITS + 1;
    localparam int MUL_B_W = (GAIN_BITS > FADE_BITS) ? GAIN_BITS : FADE_BITS;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: quotient bits, dividend bits, step counter
    localparam int DIV_Q_W   = (SAMPLE_BITS > FADE_BITS) ? SAMPLE_BITS : FADE_BITS;
    localparam int DIV_N_W   = DIV_Q_W + FADE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam int MIX_W = SAMPLE_BITS + 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [FADE_BITS-1:0]   t_fade;
    typedef logic signed [MUL_A_W-1:0]     t_mul_a;
    typedef logic        [MUL_B_W-1:0]     t_mul_b;
    typedef logic signed [MUL_P_W-1:0]     t_prod;
    typedef logic        [DIV_N_W-1:0]     t_dividend;
    typedef logic        [DIV_Q_W-1:0]     t_quot;
    typedef logic signed [MIX_W-1:0]       t_mix;

endpackage

// ===== rtl/ssx_mul.sv =====
// ssx_mul: shared signed-by-unsigned multiplier with a registered product.
// Depends on ssx_pkg for operand and product types.
module ssx_mul import ssx_pkg::*; (
    input  logic   i_clk,
    input  t_mul_a i_a,
    input  t_mul_b i_b,
    output t_prod  o_p
);

    logic signed [MUL_P_W:0] w_full;
    t_prod                   r_p;

    assign w_full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_p <= w_full[MUL_P_W-1:0];
    end

    assign o_p = r_p;

endmodule

// ===== rtl/ssx_div.sv =====
// ssx_div: restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ssx_pkg; the dividend's top FADE_BITS must be below the divisor.
module ssx_div import ssx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_dividend i_dividend,
    input  t_fade     i_divisor,
    output logic      o_done,
    output t_quot     o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_fade                r_rem;
    t_fade                r_den;
    t_quot                r_q;

    logic [FADE_BITS:0]   w_trial;
    logic                 w_ge;
    logic [FADE_BITS:0]   w_diff;

    assign w_trial = {r_rem, r_q[DIV_Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIV_N_W-1:DIV_Q_W];
            r_q   <= i_dividend[DIV_Q_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[FADE_BITS-1:0] : w_trial[FADE_BITS-1:0];
            r_q   <= {r_q[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/source_select_crossfade.sv =====
// source_select_crossfade: input selector with linear crossfade between two selections.
// Depends on ssx_pkg, ssx_mul (shared multiplier) and ssx_div (serial divider).
//
//   channel | direction | handshake                  | payload
//   in      | to block  | i_in_valid / o_in_stall    | kind, source_index, left/right_in, gain,
//           |           |                            | last_source, new_selection
//   out     | from block| o_out_valid / i_out_stall  | left/right_out, fading, silent
//   cfg     | to block  | i_cfg_we                   | fade_samples
//
// Event: no arithmetic when the latched fade length is zero, else a multiply and serial divide.
// Frame: left and right scaled unless silent; a last frame adds the emit and output steps.
// Last frame while fading: four multiply/divide terms, each through the shared multiplier
// and the serial divider (one quotient bit per cycle).
// Synchronous active-low reset; o_in_stall is high whenever the sequencer is busy.
// A result waits in the output register; the next result stalls input until it drains.
module source_select_crossfade import ssx_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_kind,
    input  logic [IDX_BITS-1:0]    i_source_index,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    input  logic [GAIN_BITS-1:0]   i_gain,
    input  logic                   i_last_source,
    input  logic [SEL_BITS-1:0]    i_new_selection,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic                   o_fading,
    output logic                   o_silent,
    input  logic                   i_cfg_we,
    input  logic [FADE_BITS-1:0]   i_cfg_wdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EV_MUL  = 4'd1;
    localparam logic [3:0] S_EV_DIV  = 4'd2;
    localparam logic [3:0] S_EV_WAIT = 4'd3;
    localparam logic [3:0] S_SC_L    = 4'd4;
    localparam logic [3:0] S_SC_R    = 4'd5;
    localparam logic [3:0] S_SC_DONE = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_MX_MUL  = 4'd8;
    localparam logic [3:0] S_MX_DIV  = 4'd9;
    localparam logic [3:0] S_MX_WAIT = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    function automatic t_sample sat_sample(input t_prod v);
        logic hi_same;
        hi_same = (v[MUL_P_W-1:SAMPLE_BITS-1] == '0) || (v[MUL_P_W-1:SAMPLE_BITS-1] == '1);
        if (hi_same) begin
            sat_sample = v[SAMPLE_BITS-1:0];
        end else if (v[MUL_P_W-1]) begin
            sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic t_sample route_acc(input logic [SEL_BITS-1:0] sel,
                                          input logic [IDX_BITS-1:0] idx,
                                          input t_sample acc,
                                          input t_sample s);
        logic [SEL_BITS-1:0] tag;
        t_prod               sum;
        tag = SEL_BITS'(idx) + SEL_BITS'(1);
        sum = t_prod'(acc) + t_prod'(s);
        route_acc = acc;
        if (sel == SEL_ALL) begin
            route_acc = sat_sample(sum);
        end else if (sel != SEL_NONE && sel == tag) begin
            route_acc = s;
        end
    endfunction

    logic [3:0]          r_state, n_state;
    t_fade               r_fade_samples, n_fade_samples;
    logic [SEL_BITS-1:0] r_sel, n_sel;
    logic [SEL_BITS-1:0] r_prev_sel, n_prev_sel;
    t_fade               r_count, n_count;
    t_fade               r_fade_max, n_fade_max;
    t_sample             r_sel_acc [2];
    t_sample             n_sel_acc [2];
    t_sample             r_prev_acc [2];
    t_sample             n_prev_acc [2];
    logic                r_out_valid, n_out_valid;

    logic [IDX_BITS-1:0] r_idx, n_idx;
    t_sample             r_left, n_left;
    t_sample             r_right, n_right;
    logic [GAIN_BITS-1:0] r_gain, n_gain;
    logic                r_last, n_last;
    logic                r_silent, n_silent;
    logic                r_fading, n_fading;
    t_fade               r_w0, n_w0;
    t_fade               r_w1, n_w1;
    logic [1:0]          r_term, n_term;
    logic                r_neg, n_neg;
    t_mix                r_mix [2];
    t_mix                n_mix [2];
    t_sample             r_out_left, n_out_left;
    t_sample             r_out_right, n_out_right;
    logic                r_out_fading, n_out_fading;
    logic                r_out_silent, n_out_silent;

    t_mul_a              w_mul_a;
    t_mul_b              w_mul_b;
    t_prod               w_p;
    logic [MUL_P_W-1:0]  w_p_mag;
    logic                w_div_start;
    t_fade               w_divisor;
    logic                w_div_done;
    t_quot               w_quot;
    t_sample             w_scaled;
    t_sample             w_acc_term;
    t_fade               w_cn;
    t_mix                w_q_mag;
    t_mix                w_q_signed;
    logic                w_src_ok;
    logic                w_silent_now;
    logic                w_out_free;

    ssx_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    ssx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (t_dividend'(w_p_mag)),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_p_mag     = w_p[MUL_P_W-1] ? MUL_P_W'(-w_p) : MUL_P_W'(w_p);
    assign w_div_start = (r_state == S_EV_DIV) || (r_state == S_MX_DIV);
    assign w_divisor   = (r_state == S_EV_DIV) ? r_w1 : r_fade_max;
    assign w_scaled    = sat_sample(w_p >>> GAIN_SHIFT);
    assign w_acc_term  = r_term[1] ? (r_term[0] ? r_prev_acc[1] : r_prev_acc[0])
                                   : (r_term[0] ? r_sel_acc[1]  : r_sel_acc[0]);
    assign w_cn        = (r_count > r_fade_max) ? r_fade_max : r_count;
    assign w_q_mag     = t_mix'(w_quot[SAMPLE_BITS-1:0]);
    assign w_q_signed  = r_neg ? -w_q_mag : w_q_mag;
    assign w_src_ok    = SEL_BITS'(r_idx) < SEL_BITS'(NUM_SOURCES);
    assign w_silent_now = (r_count == '0) && (r_sel == SEL_NONE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_SC_L: begin
                w_mul_a = t_mul_a'(r_left);
                w_mul_b = t_mul_b'(r_gain);
            end
            S_SC_R: begin
                w_mul_a = t_mul_a'(r_right);
                w_mul_b = t_mul_b'(r_gain);
            end
            S_EV_MUL: begin
                w_mul_a = t_mul_a'(r_w0);
                w_mul_b = t_mul_b'(r_fade_max);
            end
            S_MX_MUL: begin
                w_mul_a = t_mul_a'(w_acc_term);
                w_mul_b = t_mul_b'(r_term[1] ? r_w1 : r_w0);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_fade_samples = r_fade_samples;
        n_sel          = r_sel;
        n_prev_sel     = r_prev_sel;
        n_count        = r_count;
        n_fade_max     = r_fade_max;
        n_sel_acc      = r_sel_acc;
        n_prev_acc     = r_prev_acc;
        n_out_valid    = r_out_valid;
        n_idx          = r_idx;
        n_left         = r_left;
        n_right        = r_right;
        n_gain         = r_gain;
        n_last         = r_last;
        n_silent       = r_silent;
        n_fading       = r_fading;
        n_w0           = r_w0;
        n_w1           = r_w1;
        n_term         = r_term;
        n_neg          = r_neg;
        n_mix          = r_mix;
        n_out_left     = r_out_left;
        n_out_right    = r_out_right;
        n_out_fading   = r_out_fading;
        n_out_silent   = r_out_silent;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_fade_samples = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind) begin
                        n_prev_sel = r_sel;
                        n_sel      = (i_new_selection > SEL_ALL) ? SEL_NONE : i_new_selection;
                        n_fade_max = r_fade_samples;
                        if (r_fade_max == '0) begin
                            n_count = r_fade_samples;
                        end else begin
                            n_w0    = (r_count <= r_fade_max) ? r_fade_max - r_count : '0;
                            n_w1    = r_fade_max;
                            n_state = S_EV_MUL;
                        end
                    end else begin
                        n_idx    = i_source_index;
                        n_left   = i_left_in;
                        n_right  = i_right_in;
                        n_gain   = i_gain;
                        n_last   = i_last_source;
                        n_silent = w_silent_now;
                        if (!w_silent_now) begin
                            n_state = S_SC_L;
                        end else if (i_last_source) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EV_MUL: n_state = S_EV_DIV;
            S_EV_DIV: n_state = S_EV_WAIT;
            S_EV_WAIT: begin
                if (w_div_done) begin
                    n_count = w_quot[FADE_BITS-1:0];
                    n_state = S_IDLE;
                end
            end
            S_SC_L: n_state = S_SC_R;
            S_SC_R: begin
                if (w_src_ok) begin
                    n_sel_acc[0] = route_acc(r_sel, r_idx, r_sel_acc[0], w_scaled);
                    if (r_count != '0) begin
                        n_prev_acc[0] = route_acc(r_prev_sel, r_idx, r_prev_acc[0], w_scaled);
                    end
                end
                n_state = S_SC_DONE;
            end
            S_SC_DONE: begin
                if (w_src_ok) begin
                    n_sel_acc[1] = route_acc(r_sel, r_idx, r_sel_acc[1], w_scaled);
                    if (r_count != '0) begin
                        n_prev_acc[1] = route_acc(r_prev_sel, r_idx, r_prev_acc[1], w_scaled);
                    end
                end
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (r_silent) begin
                    n_mix[0] = '0;
                    n_mix[1] = '0;
                    n_fading = 1'b0;
                    n_state  = S_OUT;
                end else if (r_count == '0 || r_fade_max == '0) begin
                    n_mix[0] = t_mix'(r_sel_acc[0]);
                    n_mix[1] = t_mix'(r_sel_acc[1]);
                    n_fading = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    n_fading = 1'b1;
                    n_w1     = w_cn;
                    n_w0     = r_fade_max - w_cn;
                    n_term   = '0;
                    n_state  = S_MX_MUL;
                end
            end
            S_MX_MUL: n_state = S_MX_DIV;
            S_MX_DIV: begin
                n_neg   = w_p[MUL_P_W-1];
                n_state = S_MX_WAIT;
            end
            S_MX_WAIT: begin
                if (w_div_done) begin
                    if (r_term[0]) begin
                        n_mix[1] = r_term[1] ? r_mix[1] + w_q_signed : w_q_signed;
                    end else begin
                        n_mix[0] = r_term[1] ? r_mix[0] + w_q_signed : w_q_signed;
                    end
                    if (r_term == '1) begin
                        n_state = S_OUT;
                    end else begin
                        n_term  = r_term + 1'b1;
                        n_state = S_MX_MUL;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_left    = sat_sample(t_prod'(r_mix[0]));
                    n_out_right   = sat_sample(t_prod'(r_mix[1]));
                    n_out_fading  = r_fading;
                    n_out_silent  = r_silent;
                    n_count       = r_fading ? r_count - 1'b1 : '0;
                    n_sel_acc[0]  = '0;
                    n_sel_acc[1]  = '0;
                    n_prev_acc[0] = '0;
                    n_prev_acc[1] = '0;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fade_samples <= '0;
            r_sel          <= SEL_BITS'(1);
            r_prev_sel     <= SEL_BITS'(1);
            r_count        <= '0;
            r_fade_max     <= '0;
            r_sel_acc[0]   <= '0;
            r_sel_acc[1]   <= '0;
            r_prev_acc[0]  <= '0;
            r_prev_acc[1]  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_fade_samples <= n_fade_samples;
            r_sel          <= n_sel;
            r_prev_sel     <= n_prev_sel;
            r_count        <= n_count;
            r_fade_max     <= n_fade_max;
            r_sel_acc      <= n_sel_acc;
            r_prev_acc     <= n_prev_acc;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_left       <= n_left;
        r_right      <= n_right;
        r_gain       <= n_gain;
        r_last       <= n_last;
        r_silent     <= n_silent;
        r_fading     <= n_fading;
        r_w0         <= n_w0;
        r_w1         <= n_w1;
        r_term       <= n_term;
        r_neg        <= n_neg;
        r_mix        <= n_mix;
        r_out_left   <= n_out_left;
        r_out_right  <= n_out_right;
        r_out_fading <= n_out_fading;
        r_out_silent <= n_out_silent;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_left;
    assign o_right_out = r_out_right;
    assign o_fading    = r_out_fading;
    assign o_silent    = r_out_silent;

    a_mix_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MX_MUL) |-> (r_fade_max != '0 && r_w1 <= r_fade_max))
        else $error("crossfade weights out of range");

    a_rescale_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_WAIT && w_div_done) |-> (w_quot <= DIV_Q_W'(r_fade_max)))
        else $error("rescaled fade count above fade length");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_silent) |-> (o_left_out == '0 && o_right_out == '0 && !o_fading))
        else $error("silent result carries data");

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for source_select_crossfade.
// Depends on ssx_pkg and the block RTL; predicts each mixed frame and checks every
// output transfer against it under random input gaps and output stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ssx_pkg::*;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EVENT = 1'b1;
    localparam longint SAMPLE_MAX = 64'sd8388607;
    localparam longint SAMPLE_MIN = -64'sd8388608;
    localparam t_fade FADE_MAX = '1;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 990;

    typedef struct {
        logic                kind;
        logic [IDX_BITS-1:0] idx;
        t_sample             left;
        t_sample             right;
        logic [GAIN_BITS-1:0] gain;
        logic                last;
        logic [SEL_BITS-1:0] nsel;
    } t_mix_in;

    typedef struct {
        t_sample left;
        t_sample right;
        logic    fading;
        logic    silent;
    } t_mix_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_kind;
    logic [IDX_BITS-1:0]   i_source_index;
    t_sample               i_left_in;
    t_sample               i_right_in;
    logic [GAIN_BITS-1:0]  i_gain;
    logic                  i_last_source;
    logic [SEL_BITS-1:0]   i_new_selection;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_sample               o_left_out;
    t_sample               o_right_out;
    logic                  o_fading;
    logic                  o_silent;
    logic                  i_cfg_we;
    t_fade                 i_cfg_wdata;

    // predictor state
    logic [SEL_BITS-1:0] cur_sel;
    logic [SEL_BITS-1:0] old_sel;
    t_fade               fade_len;
    t_fade               fade_cnt;
    t_fade               fade_top;
    longint              sel_sum_l, sel_sum_r, old_sum_l, old_sum_r;

    t_mix_out expected_mix_q[$];
    int       mismatches;
    int       items_sent;
    int       in_idle_pct;
    int       out_idle_pct;
    int       stall_left;
    logic     hold_req;
    int       timeout_cycles;

    source_select_crossfade u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_source_index  (i_source_index),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_gain          (i_gain),
        .i_last_source   (i_last_source),
        .i_new_selection (i_new_selection),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_fading        (o_fading),
        .o_silent        (o_silent),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip24(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    function automatic longint apply_gain(input t_sample s, input logic [GAIN_BITS-1:0] g);
        longint sl;
        longint gl;
        sl = s;
        gl = g;
        return clip24((sl * gl) >>> GAIN_SHIFT);
    endfunction

    task automatic route_into(input logic [SEL_BITS-1:0] which, input logic [IDX_BITS-1:0] idx,
                              input longint vl, input longint vr,
                              inout longint acc_l, inout longint acc_r);
        if (which == SEL_ALL) begin
            acc_l = clip24(acc_l + vl);
            acc_r = clip24(acc_r + vr);
        end else if (which != SEL_NONE && {1'b0, idx} == which - 1) begin
            acc_l = vl;
            acc_r = vr;
        end
    endtask

    task automatic predict_mix(input t_mix_in it);
        longint   old_top, rem, mx, cn, vl, vr;
        logic     quiet;
        t_mix_out res;
        if (it.kind == KIND_EVENT) begin
            old_top = fade_top;
            old_sel = cur_sel;
            cur_sel = (it.nsel > SEL_ALL) ? SEL_NONE : it.nsel;
            fade_top = fade_len;
            if (old_top == 0) begin
                fade_cnt = fade_top;
            end else begin
                rem = (fade_cnt <= old_top) ? old_top - longint'(fade_cnt) : 0;
                fade_cnt = t_fade'((rem * longint'(fade_top)) / old_top);
            end
            return;
        end
        quiet = (fade_cnt == 0 && cur_sel == SEL_NONE);
        if (!quiet) begin
            vl = apply_gain(it.left, it.gain);
            vr = apply_gain(it.right, it.gain);
            route_into(cur_sel, it.idx, vl, vr, sel_sum_l, sel_sum_r);
            if (fade_cnt > 0) route_into(old_sel, it.idx, vl, vr, old_sum_l, old_sum_r);
        end
        if (!it.last) return;
        res.fading = 1'b0;
        res.silent = quiet;
        if (quiet) begin
            res.left = '0;
            res.right = '0;
        end else if (fade_cnt == 0 || fade_top == 0) begin
            res.left = t_sample'(sel_sum_l);
            res.right = t_sample'(sel_sum_r);
            fade_cnt = '0;
        end else begin
            mx = fade_top;
            cn = fade_cnt;
            if (cn > mx) cn = mx;
            res.fading = 1'b1;
            res.left = t_sample'(clip24(sel_sum_l * (mx - cn) / mx + old_sum_l * cn / mx));
            res.right = t_sample'(clip24(sel_sum_r * (mx - cn) / mx + old_sum_r * cn / mx));
            fade_cnt = fade_cnt - 1'b1;
        end
        sel_sum_l = 0;
        sel_sum_r = 0;
        old_sum_l = 0;
        old_sum_r = 0;
        expected_mix_q.push_back(res);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0: return t_sample'(SAMPLE_MAX);
            1: return t_sample'(SAMPLE_MIN);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] rand_gain();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return GAIN_BITS'(1 << GAIN_SHIFT);
            default: return GAIN_BITS'($urandom);
        endcase
    endfunction

    function automatic t_mix_in make_frame(input logic [IDX_BITS-1:0] idx, input t_sample l,
                                           input t_sample r, input logic [GAIN_BITS-1:0] g,
                                           input logic last);
        t_mix_in it;
        it.kind = KIND_FRAME;
        it.idx = idx;
        it.left = l;
        it.right = r;
        it.gain = g;
        it.last = last;
        it.nsel = SEL_BITS'($urandom);
        return it;
    endfunction

    function automatic t_mix_in rand_frame(input logic [IDX_BITS-1:0] idx, input logic last);
        return make_frame(idx, rand_sample(), rand_sample(), rand_gain(), last);
    endfunction

    function automatic t_mix_in make_event(input logic [SEL_BITS-1:0] nsel);
        t_mix_in it;
        it = rand_frame(IDX_BITS'($urandom), 1'($urandom));
        it.kind = KIND_EVENT;
        it.nsel = nsel;
        return it;
    endfunction

    task automatic send_item(input t_mix_in it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= it.kind;
        i_source_index  <= it.idx;
        i_left_in       <= it.left;
        i_right_in      <= it.right;
        i_gain          <= it.gain;
        i_last_source   <= it.last;
        i_new_selection <= it.nsel;
        do @(posedge i_clk); while (o_in_stall);
        predict_mix(it);
        items_sent++;
    endtask

    task automatic write_fade(input t_fade v);
        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fade_len = v;
    endtask

    task automatic check_mix_out();
        t_mix_out want;
        if (expected_mix_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual left %0d right %0d",
                     $time, o_left_out, o_right_out);
            mismatches++;
            return;
        end
        want = expected_mix_q.pop_front();
        if (o_left_out !== want.left) begin
            $display("%0t: left_out expected %0d actual %0d", $time, want.left, o_left_out);
            mismatches++;
        end
        if (o_right_out !== want.right) begin
            $display("%0t: right_out expected %0d actual %0d", $time, want.right, o_right_out);
            mismatches++;
        end
        if (o_fading !== want.fading) begin
            $display("%0t: fading expected %0b actual %0b", $time, want.fading, o_fading);
            mismatches++;
        end
        if (o_silent !== want.silent) begin
            $display("%0t: silent expected %0b actual %0b", $time, want.silent, o_silent);
            mismatches++;
        end
    endtask

    // output side: checks each transfer, then picks the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_mix_out();
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    initial begin
        for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // default selection is source 0 with no fade
    task automatic test_reset_selection();
        send_item(make_frame(4'd0, t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), '1, 1'b0));
        send_item(rand_frame(4'd1, 1'b1));
        send_item(make_frame(4'd0, t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX), '0, 1'b1));
    endtask

    task automatic test_selection_codes();
        send_item(make_event(SEL_ALL));
        send_item(make_frame(4'd3, t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), '1, 1'b0));
        send_item(make_frame(4'd9, t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), '1, 1'b0));
        send_item(make_frame(4'd2, t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN),
                             GAIN_BITS'(1 << GAIN_SHIFT), 1'b1));
        send_item(make_event(SEL_NONE));
        send_item(rand_frame(4'd5, 1'b1));
        send_item(make_event(5'h1F));
        send_item(rand_frame(4'd6, 1'b1));
        // source 15 selected but absent from the frame
        send_item(make_event(5'd16));
        send_item(rand_frame(4'd3, 1'b1));
        send_item(make_event(SEL_ALL + 5'd1));
    endtask

    task automatic test_fade_retarget();
        write_fade(t_fade'(3));
        send_item(make_event(SEL_ALL));
        send_item(rand_frame(4'd4, 1'b0));
        send_item(rand_frame(4'd11, 1'b1));
        send_item(rand_frame(4'd0, 1'b1));
        send_item(make_event(5'd1));
        send_item(rand_frame(4'd0, 1'b0));
        send_item(rand_frame(4'd7, 1'b1));
        send_item(make_event(SEL_ALL));
        write_fade(FADE_MAX);
        send_item(make_event(5'd16));
        send_item(rand_frame(4'd15, 1'b1));
        write_fade('0);
        send_item(make_event(SEL_NONE));
        send_item(rand_frame(4'd8, 1'b1));
    endtask

    task automatic test_output_backpressure();
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_fade(t_fade'(6));
        send_item(make_event(SEL_ALL));
        hold_req <= 1'b1;
        repeat (40) send_item(rand_frame(IDX_BITS'($urandom), 1'b1));
    endtask

    function automatic t_fade pick_fade();
        case ($urandom_range(5))
            0: return '0;
            1: return FADE_MAX;
            2: return t_fade'($urandom_range(1, 1048575));
            default: return t_fade'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic test_random_traffic();
        int target, r, n, start, k;
        for (int ph = 0; ph < 3; ph++) begin
            in_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 49 : 0;
            out_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 10 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                write_fade(pick_fade());
                target = items_sent + RANDOM_ITEMS / 9;
                while (items_sent < target) begin
                    r = $urandom_range(99);
                    if (r < 12) begin
                        send_item(make_event(($urandom_range(3) == 0) ?
                                             SEL_BITS'($urandom) :
                                             SEL_BITS'($urandom_range(17))));
                    end else if (r < 20) begin
                        send_item(rand_frame(IDX_BITS'($urandom), 1'($urandom)));
                    end else begin
                        n = ($urandom_range(9) == 0) ? NUM_SOURCES : $urandom_range(1, 6);
                        start = $urandom_range(NUM_SOURCES - 1);
                        for (k = 0; k < n; k++)
                            send_item(rand_frame(IDX_BITS'(start + k), k == n - 1));
                    end
                end
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_FRAME;
        i_source_index = '0;
        i_left_in = '0;
        i_right_in = '0;
        i_gain = '0;
        i_last_source = 1'b0;
        i_new_selection = SEL_NONE;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        hold_req = 1'b0;
        stall_left = 0;
        mismatches = 0;
        items_sent = 0;
        cur_sel = SEL_BITS'(1);
        old_sel = SEL_BITS'(1);
        fade_len = '0;
        fade_cnt = '0;
        fade_top = '0;
        sel_sum_l = 0;
        sel_sum_r = 0;
        old_sum_l = 0;
        old_sum_r = 0;
        in_idle_pct = 10;
        out_idle_pct = 49;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_selection();
        test_selection_codes();
        test_fade_retarget();
        test_random_traffic();
        test_output_backpressure();

        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_mix_q.size() != 0) begin
            $display("%0t: %0d expected transfers never arrived", $time, expected_mix_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssx_pkg.sv
rtl/ssx_mul.sv
rtl/ssx_div.sv
rtl/source_select_crossfade.sv
test/tb_top.sv
